@@ rtl/core/fsht_pkg.sv @@
// Shared constants, result codes and the cell command type of the hit table.
`default_nettype none

package fsht_pkg;

  localparam int ENTRIES_DEF = 32;
  localparam int ADDR_W      = 64;
  localparam int CNT_W       = 32;
  localparam int SLOT_W      = 5;
  localparam int FILL_W      = 6;
  localparam int STATUS_W    = 2;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_HIT  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ADD  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROP = 2'd2;
  localparam logic [STATUS_W-1:0] ST_READ = 2'd3;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic              upd;
    logic              op;
    logic              hit;
    logic              append;
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  cnt;
  } fsht_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/frequency_sorted_hit_table.sv @@
// Top level: controller and row of cells of the frequency-sorted hit table.
//
//  channel   signals                                        handshake
//  -------   --------------------------------------------   -------------------------
//  command   op, address, slot                              taken when start && !busy
//  result    status, entry_valid, entry_address,            one cycle, marked by done
//            entry_count, position, fill, full_res
//
// Each command passes through a match state, which compares all cells against the
// address (or picks the slot to read), and an update state, which raises the count and
// shifts the run of cells ahead of the hit by one place; the result beat follows.
// A new command is taken in the cycle that shows done.
// Synchronous reset empties the table by clearing the fill level; no clearing pass.
// The receiver cannot stall the result beat.
`default_nettype none

module frequency_sorted_hit_table import fsht_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                op,
  input  logic [ADDR_W-1:0]   address,
  input  logic [SLOT_W-1:0]   slot,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic                entry_valid,
  output logic [ADDR_W-1:0]   entry_address,
  output logic [CNT_W-1:0]    entry_count,
  output logic [SLOT_W-1:0]   position,
  output logic [FILL_W-1:0]   fill,
  output logic                full_res
);

  localparam int IW = $clog2(ENTRIES);
  localparam int FW = $clog2(ENTRIES + 1);
  localparam logic [FW-1:0] FULL_F = FW'(ENTRIES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_MATCH  = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic              req_op;
  logic [ADDR_W-1:0] req_addr;
  logic [SLOT_W-1:0] req_slot;
  logic [FW-1:0]     fill_level;
  logic [FW-1:0]     fill_level_next;
  logic              hit_q;
  logic [IW-1:0]     hit_idx;
  logic [ADDR_W-1:0] sel_addr_q;
  logic [CNT_W-1:0]  sel_cnt_q;

  logic [ADDR_W-1:0] cell_addr [ENTRIES];
  logic [CNT_W-1:0]  cell_cnt  [ENTRIES];
  logic [ENTRIES-1:0] sel_vec;
  logic [ENTRIES-1:0] move_vec;
  logic [ENTRIES-1:0] wr_vec;

  logic              sel_any;
  logic [ADDR_W-1:0] sel_addr;
  logic [CNT_W-1:0]  sel_cnt;
  logic [IW-1:0]     sel_idx;
  logic              wr_any;
  logic [IW-1:0]     wr_idx;
  logic [CNT_W-1:0]  cnt_new;
  logic              full_now;
  logic              accept;
  fsht_cmd_t         cmd;

  logic [STATUS_W-1:0] status_next;
  logic                valid_next;
  logic [ADDR_W-1:0]   addr_next;
  logic [CNT_W-1:0]    count_next;
  logic [SLOT_W-1:0]   position_next;

  logic [IW-1:0]          pos_hit;
  logic [IW+SLOT_W-1:0]   pos_hit_wide;
  logic [FW+SLOT_W-1:0]   pos_add_wide;
  logic [FW+FILL_W-1:0]   fill_wide;

  assign busy     = state != S_IDLE;
  assign accept   = start && !busy;
  assign full_now = fill_level == FULL_F;
  assign cnt_new  = (sel_cnt_q == '1) ? sel_cnt_q : sel_cnt_q + CNT_W'(1);

  always_comb begin
    cmd.upd    = state == S_UPDATE;
    cmd.op     = req_op;
    cmd.hit    = (state == S_UPDATE) && (req_op == OP_RECORD) && hit_q;
    cmd.append = (state == S_UPDATE) && (req_op == OP_RECORD) && !hit_q && !full_now;
    cmd.addr   = req_addr;
    cmd.slot   = req_slot;
    cmd.cnt    = cnt_new;
  end

  for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
    if (j == 0) begin : g_head
      fsht_cell #(.IDX(j), .IW(IW), .FW(FW)) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .hit_idx    (hit_idx),
        .fill_level (fill_level),
        .left_addr  ('0),
        .left_count ('0),
        .left_move  (1'b0),
        .addr_q     (cell_addr[j]),
        .count_q    (cell_cnt[j]),
        .sel        (sel_vec[j]),
        .move       (move_vec[j])
      );
      assign wr_vec[j] = move_vec[j];
    end else begin : g_body
      fsht_cell #(.IDX(j), .IW(IW), .FW(FW)) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .hit_idx    (hit_idx),
        .fill_level (fill_level),
        .left_addr  (cell_addr[j-1]),
        .left_count (cell_cnt[j-1]),
        .left_move  (move_vec[j-1]),
        .addr_q     (cell_addr[j]),
        .count_q    (cell_cnt[j]),
        .sel        (sel_vec[j]),
        .move       (move_vec[j])
      );
      assign wr_vec[j] = move_vec[j] && !move_vec[j-1];
    end
  end

  // AND-OR gather of the selected cell; at most one cell is selected.
  always_comb begin
    sel_addr = '0;
    sel_cnt  = '0;
    sel_idx  = '0;
    wr_idx   = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (sel_vec[j]) begin
        sel_addr = sel_addr | cell_addr[j];
        sel_cnt  = sel_cnt | cell_cnt[j];
        sel_idx  = sel_idx | IW'(j);
      end
      if (wr_vec[j]) begin
        wr_idx = wr_idx | IW'(j);
      end
    end
    sel_any = |sel_vec;
    wr_any  = |wr_vec;
  end

  // A saturated count keeps its place: no cell moves.
  assign pos_hit      = wr_any ? wr_idx : hit_idx;
  assign pos_hit_wide = {{SLOT_W{1'b0}}, pos_hit};
  assign pos_add_wide = {{SLOT_W{1'b0}}, fill_level};
  assign fill_wide    = {{FILL_W{1'b0}}, fill_level_next};

  always_comb begin
    fill_level_next = fill_level;
    status_next     = ST_READ;
    valid_next      = sel_any;
    addr_next       = sel_addr_q;
    count_next      = sel_cnt_q;
    position_next   = req_slot;
    priority if (req_op == OP_READ) begin
      valid_next    = hit_q;
    end else if (hit_q) begin
      status_next   = ST_HIT;
      valid_next    = 1'b1;
      addr_next     = req_addr;
      count_next    = cnt_new;
      position_next = pos_hit_wide[SLOT_W-1:0];
    end else if (!full_now) begin
      fill_level_next = fill_level + FW'(1);
      status_next     = ST_ADD;
      valid_next      = 1'b1;
      addr_next       = req_addr;
      count_next      = CNT_W'(1);
      position_next   = pos_add_wide[SLOT_W-1:0];
    end else begin
      status_next   = ST_DROP;
      valid_next    = 1'b0;
      addr_next     = req_addr;
      count_next    = '0;
      position_next = '0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_MATCH;
      S_MATCH:  state_next = S_UPDATE;
      S_UPDATE: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_level <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == S_UPDATE;
      if (state == S_UPDATE) begin
        fill_level <= fill_level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= op;
      req_addr <= address;
      req_slot <= slot;
    end
    // Hold the matched or read entry for the update cycle.
    if (state == S_MATCH) begin
      hit_q      <= sel_any;
      hit_idx    <= sel_idx;
      sel_addr_q <= sel_addr;
      sel_cnt_q  <= sel_cnt;
    end
    if (state == S_UPDATE) begin
      status        <= status_next;
      entry_valid   <= valid_next;
      entry_address <= addr_next;
      entry_count   <= count_next;
      position      <= position_next;
      fill          <= fill_wide[FILL_W-1:0];
      full_res      <= fill_level_next == FULL_F;
    end
  end

  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_UPDATE)
    else $error("result beat without an update cycle");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted command did not raise busy");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (fill_level == $past(fill_level) || fill_level == $past(fill_level) + FW'(1)))
    else $error("fill level moved by more than one");

  a_one_insert: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) |-> $onehot0(wr_vec))
    else $error("moving run of cells is not contiguous");

endmodule

`default_nettype wire

@@ rtl/core/fsht_cell.sv @@
// One table slot: holds an address and its count, compares, and shifts from its left neighbor.
`default_nettype none

module fsht_cell import fsht_pkg::*; #(
  parameter int IDX = 0,
  parameter int IW  = 5,
  parameter int FW  = 6
) (
  input  logic              clk,
  input  fsht_cmd_t         cmd,
  input  logic [IW-1:0]     hit_idx,
  input  logic [FW-1:0]     fill_level,
  input  logic [ADDR_W-1:0] left_addr,
  input  logic [CNT_W-1:0]  left_count,
  input  logic              left_move,
  output logic [ADDR_W-1:0] addr_q,
  output logic [CNT_W-1:0]  count_q,
  output logic              sel,
  output logic              move
);

  localparam logic [FW-1:0]     IDX_F      = FW'(IDX);
  localparam logic [IW-1:0]     IDX_I      = IW'(IDX);
  localparam logic [SLOT_W-1:0] IDX_S      = SLOT_W'(IDX);
  localparam bit                SLOT_REACH = (IDX < (1 << SLOT_W));

  logic valid;
  logic match;
  logic slot_hit;
  logic take;
  logic put;
  logic app;

  assign valid    = IDX_F < fill_level;
  assign match    = valid && (addr_q == cmd.addr);
  assign slot_hit = valid && SLOT_REACH && (IDX_S == cmd.slot);
  assign sel      = (cmd.op == OP_READ) ? slot_hit : match;

  // Cells from the insert point up to the hit form one contiguous run.
  assign move = cmd.hit && (IDX_I <= hit_idx) && (count_q < cmd.cnt);
  assign take = move && left_move;
  assign put  = move && !left_move;
  assign app  = cmd.append && (IDX_F == fill_level);

  // Hold the slot unless it shifts, takes the hit, or takes the appended address.
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      if (take) begin
        addr_q  <= left_addr;
        count_q <= left_count;
      end else if (put) begin
        addr_q  <= cmd.addr;
        count_q <= cmd.cnt;
      end else if (app) begin
        addr_q  <= cmd.addr;
        count_q <= CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ sim/hit_table_checker.sv @@
// Checker for the hit table: tracks the table contents, predicts each result beat, compares.
`timescale 1ns / 1ps

module hit_table_checker import fsht_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic                op,
  input  logic [ADDR_W-1:0]   address,
  input  logic [SLOT_W-1:0]   slot,
  input  logic                done,
  input  logic [STATUS_W-1:0] status,
  input  logic                entry_valid,
  input  logic [ADDR_W-1:0]   entry_address,
  input  logic [CNT_W-1:0]    entry_count,
  input  logic [SLOT_W-1:0]   position,
  input  logic [FILL_W-1:0]   fill,
  input  logic                full_res,
  output int                  mismatch_count,
  output int                  results_due
);

  localparam int ENTRIES = ENTRIES_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                valid;
    logic [ADDR_W-1:0]   addr;
    logic [CNT_W-1:0]    cnt;
    logic [SLOT_W-1:0]   pos;
    logic [FILL_W-1:0]   fill;
    logic                full;
  } table_result_t;

  logic [ADDR_W-1:0] table_addr [ENTRIES];
  logic [CNT_W-1:0]  table_cnt  [ENTRIES];
  int                used_slots;
  table_result_t     pending_results [$];
  table_result_t     want;

  initial mismatch_count = 0;
  initial results_due = 0;

  // Apply one command to the table copy and queue the result it should give.
  task automatic model_hit_table(input logic cmd_op, input logic [ADDR_W-1:0] cmd_addr,
                                 input logic [SLOT_W-1:0] cmd_slot);
    table_result_t    r;
    int               hit_idx;
    int               p;
    int               i;
    logic [CNT_W-1:0] c;
    r = '0;
    if (cmd_op == OP_READ) begin
      r.status = ST_READ;
      r.pos    = cmd_slot;
      if (int'(cmd_slot) < used_slots) begin
        r.valid = 1'b1;
        r.addr  = table_addr[cmd_slot];
        r.cnt   = table_cnt[cmd_slot];
      end
    end else begin
      hit_idx = -1;
      for (i = 0; i < used_slots; i++) begin
        if (hit_idx < 0 && table_addr[i] == cmd_addr) hit_idx = i;
      end
      if (hit_idx >= 0) begin
        c = table_cnt[hit_idx];
        if (c != '1) c = c + 1'b1;
        p = hit_idx;
        // Shift smaller counts back one place; equal counts stay ahead.
        while (p > 0 && table_cnt[p-1] < c) begin
          table_addr[p] = table_addr[p-1];
          table_cnt[p]  = table_cnt[p-1];
          p--;
        end
        table_addr[p] = cmd_addr;
        table_cnt[p]  = c;
        r.status = ST_HIT;
        r.valid  = 1'b1;
        r.addr   = cmd_addr;
        r.cnt    = c;
        r.pos    = SLOT_W'(p);
      end else if (used_slots >= ENTRIES) begin
        r.status = ST_DROP;
        r.addr   = cmd_addr;
      end else begin
        table_addr[used_slots] = cmd_addr;
        table_cnt[used_slots]  = CNT_W'(1);
        r.status = ST_ADD;
        r.valid  = 1'b1;
        r.addr   = cmd_addr;
        r.cnt    = CNT_W'(1);
        r.pos    = SLOT_W'(used_slots);
        used_slots++;
      end
    end
    r.fill = FILL_W'(used_slots);
    r.full = (used_slots >= ENTRIES);
    pending_results.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      used_slots = 0;
      pending_results.delete();
    end else begin
      // A result beat and a new command can share an edge; retire the result first.
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no command outstanding");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatch_count++;
          end
          if (entry_valid !== want.valid) begin
            $error("entry_valid: expected %0d, got %0d", want.valid, entry_valid);
            mismatch_count++;
          end
          if (entry_address !== want.addr) begin
            $error("entry_address: expected %h, got %h", want.addr, entry_address);
            mismatch_count++;
          end
          if (entry_count !== want.cnt) begin
            $error("entry_count: expected %0d, got %0d", want.cnt, entry_count);
            mismatch_count++;
          end
          if (position !== want.pos) begin
            $error("position: expected %0d, got %0d", want.pos, position);
            mismatch_count++;
          end
          if (fill !== want.fill) begin
            $error("fill: expected %0d, got %0d", want.fill, fill);
            mismatch_count++;
          end
          if (full_res !== want.full) begin
            $error("full_res: expected %0d, got %0d", want.full, full_res);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) model_hit_table(op, address, slot);
    end
    results_due <= pending_results.size();
  end

endmodule

@@ sim/frequency_sorted_hit_table_test.sv @@
// Testbench top: drives commands into the hit table and reports the verdict.
`timescale 1ns / 1ps

module frequency_sorted_hit_table_test;
  import fsht_pkg::*;

  localparam int POOL_SIZE  = 40;
  localparam int PHASE_BEATS = 535;
  localparam int STALL_LIMIT = 1000;

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                op = OP_RECORD;
  logic [ADDR_W-1:0]   address = '0;
  logic [SLOT_W-1:0]   slot = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic                entry_valid;
  logic [ADDR_W-1:0]   entry_address;
  logic [CNT_W-1:0]    entry_count;
  logic [SLOT_W-1:0]   position;
  logic [FILL_W-1:0]   fill;
  logic                full_res;

  int                  mismatch_count;
  int                  results_due;
  int                  idle_pct = 0;
  int                  quiet_cycles = 0;
  int                  phase_idle [3] = '{19, 88, 0};
  logic [ADDR_W-1:0]   hot_addrs [POOL_SIZE];

  frequency_sorted_hit_table dut (
    .clk, .rst, .start, .busy, .op, .address, .slot, .done, .status, .entry_valid,
    .entry_address, .entry_count, .position, .fill, .full_res
  );

  hit_table_checker checker_i (
    .clk, .rst, .start, .busy, .op, .address, .slot, .done, .status, .entry_valid,
    .entry_address, .entry_count, .position, .fill, .full_res,
    .mismatch_count, .results_due
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Present one command, idling first at the current rate, and hold it until taken.
  task automatic issue_beat(input logic cmd_op, input logic [ADDR_W-1:0] cmd_addr,
                            input logic [SLOT_W-1:0] cmd_slot);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start   <= 1'b1;
    op      <= cmd_op;
    address <= cmd_addr;
    slot    <= cmd_slot;
    do @(posedge clk); while (busy);
  endtask

  // Drop out if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) hot_addrs[i] = {$urandom, $urandom};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reads of an empty table, then a few entries built up with ties.
    issue_beat(OP_READ, '0, 5'd0);
    issue_beat(OP_READ, '1, 5'd31);
    issue_beat(OP_RECORD, '0, 5'd0);
    issue_beat(OP_RECORD, '1, 5'd31);
    issue_beat(OP_RECORD, {32{2'b01}}, 5'd0);
    issue_beat(OP_RECORD, {32{2'b10}}, 5'd0);
    issue_beat(OP_READ, '0, 5'd31);
    issue_beat(OP_RECORD, {32{2'b10}}, 5'd0);
    issue_beat(OP_RECORD, '1, 5'd0);
    issue_beat(OP_RECORD, {32{2'b01}}, 5'd0);
    issue_beat(OP_RECORD, '0, 5'd0);
    issue_beat(OP_RECORD, '0, 5'd0);
    for (int s = 0; s < 5; s++) issue_beat(OP_READ, '0, SLOT_W'(s));

    // Skewed picks from a hot set fill the table, reorder it, then hit drops.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = phase_idle[phase];
      repeat (PHASE_BEATS) begin
        if ($urandom_range(0, 3) == 0)
          issue_beat(OP_READ, {$urandom, $urandom}, SLOT_W'($urandom));
        else if ($urandom_range(0, 19) == 0)
          issue_beat(OP_RECORD, {$urandom, $urandom}, SLOT_W'($urandom));
        else
          issue_beat(OP_RECORD, hot_addrs[$urandom_range(0, $urandom_range(0, POOL_SIZE-1))],
                     SLOT_W'($urandom));
      end
      if (phase == 0) begin
        // Hold off until the block has drained.
        start <= 1'b0;
        do @(posedge clk); while (results_due != 0);
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/fsht_pkg.sv
rtl/core/fsht_cell.sv
rtl/core/frequency_sorted_hit_table.sv
sim/hit_table_checker.sv
sim/frequency_sorted_hit_table_test.sv
